// ===== rtl/ard_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ard_pkg: shared types and constants for the audio requantizer core
// Register indexes, quantizer modes and sequencer states.
// ----------------------------------------------------------------------------
package ard_pkg;

  localparam int unsigned MaxChannels = 8;

  localparam logic [31:0] LcgMul = 32'd1664525;
  localparam logic [31:0] LcgAdd = 32'd1013904223;

  typedef enum logic [2:0] {
    REG_SRC_CH  = 3'd0,
    REG_DST_CH  = 3'd1,
    REG_BITS    = 3'd2,
    REG_SIGNED  = 3'd3,
    REG_LITTLE  = 3'd4,
    REG_QMODE   = 3'd5
  } reg_idx_e;

  typedef enum logic [1:0] {
    QM_TRUNC = 2'd0,
    QM_EFB   = 2'd1,
    QM_TPDF  = 2'd2,
    QM_SHAPE = 2'd3
  } qmode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LCG1,
    ST_LCG2,
    ST_SHAPE,
    ST_QUANT,
    ST_ERR,
    ST_EMIT,
    ST_CLEAR
  } state_e;

endpackage

// ===== rtl/ard_lcg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ard_lcg: shared LCG step unit
// One multiply-add of the dither generator, registered at the output.
// ----------------------------------------------------------------------------
module ard_lcg (
  input  logic        clk_i,
  input  logic [31:0] seed_i,
  output logic [31:0] seed_o
);

  always_ff @(posedge clk_i) begin
    seed_o <= seed_i * ard_pkg::LcgMul + ard_pkg::LcgAdd;
  end

endmodule

// ===== rtl/audio_requantizer_dither_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// audio_requantizer_dither_core: PCM requantizer with dither and shaping
// Maps one frame of 16-bit samples to packed code words, one per channel.
// ----------------------------------------------------------------------------
//  channel   direction  handshake         payload
//  s_axis    in         tvalid/tready     tdata chan_0..7, tlast final_frame
//  m_axis    out        tvalid/tready     tdata code_word, tuser ch/cnt, tlast last
//  cfg       in         cfg_valid/ready   cfg_index, cfg_data
//
//  Each output word passes through quantize, error update and emit. At widths
//  below 16 bits, TPDF mode first steps the seed through the shared LCG unit
//  (states LCG1, LCG2) and third-order mode first runs the shaping filter
//  (state SHAPE). Emit holds while the output register still carries an
//  untaken word. After a non-final frame the input side is ready again once
//  its last word is loaded into the output register. A final frame first adds
//  a sweep over all MAX_CHANNELS channels clearing error and seed state. Reset zeroes
//  the sequencer, error and seed state at once and sets the config registers to defaults.
module audio_requantizer_dither_core #(
  parameter int unsigned MAX_CHANNELS = ard_pkg::MaxChannels
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [127:0] s_axis_tdata,   // chan_0 .. chan_7, 16 bits each
  input  logic        s_axis_tlast,    // final_frame
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,    // code_word
  output logic [7:0]  m_axis_tuser,    // out_channel[2:0], byte_count[5:3], zero[7:6]
  output logic        m_axis_tlast,    // last_of_frame
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  localparam int unsigned CW = $clog2(MAX_CHANNELS + 1);
  localparam int unsigned IW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

  // reciprocals for the divides by 10 and by 100 (95/100 taken as 19/20)
  localparam logic [22:0] Recip10    = 23'd6710887;   // ceil(2^26 / 10)
  localparam logic [24:0] Recip95Pct = 25'd31876718;  // 19 * ceil(2^25 / 20)

  ard_pkg::state_e state_q, state_d, chan_st;

  logic [3:0] src_q, dst_q;
  logic [5:0] bits_q;
  logic       sgn_q, le_q;
  logic [1:0] qm_q;

  logic signed [15:0] smp_q [MAX_CHANNELS];
  logic               fin_q;
  logic [IW-1:0]      oc_q, oc_d;
  logic [IW-1:0]      mod_q;       // oc mod nsrc, tracked incrementally
  logic signed [16:0] eh_q [MAX_CHANNELS][3];
  logic [31:0]        seed_q [MAX_CHANNELS];
  logic [14:0]        r1_q;
  logic signed [16:0] s_q;         // clamped pre-quantizer sample
  logic signed [32:0] q_q;
  logic signed [19:0] shp_q;       // registered shaping feedback
  logic [31:0]        word_q;
  logic [2:0]         nb_q;
  logic               last_q, out_v_q;

  // effective config
  logic [CW-1:0] nsrc, ndst;
  logic [5:0]    bits;
  logic [4:0]    sh;
  always_comb begin
    nsrc = (src_q == 4'd0) ? CW'(1) :
           (32'(src_q) > MAX_CHANNELS) ? CW'(MAX_CHANNELS) : CW'(src_q);
    ndst = (dst_q == 4'd0) ? CW'(1) :
           (32'(dst_q) > MAX_CHANNELS) ? CW'(MAX_CHANNELS) : CW'(dst_q);
    bits = (bits_q == 6'd0) ? 6'd1 : (bits_q > 6'd32) ? 6'd32 : bits_q;
    sh   = 5'(6'd16 - bits);
  end

  logic narrow;
  assign narrow = bits < 6'd16;

  // first state of each output channel
  always_comb begin
    chan_st = ard_pkg::ST_QUANT;
    if (narrow && qm_q == ard_pkg::QM_TPDF) chan_st = ard_pkg::ST_LCG1;
    else if (narrow && qm_q == ard_pkg::QM_SHAPE) chan_st = ard_pkg::ST_SHAPE;
  end

  // shared LCG unit
  logic [31:0] lcg_in, lcg_out;
  assign lcg_in = (state_q == ard_pkg::ST_LCG1) ? seed_q[oc_q] : lcg_out;
  ard_lcg u_lcg (.clk_i(clk_i), .seed_i(lcg_in), .seed_o(lcg_out));

  // source select
  logic signed [17:0] src_s;
  always_comb begin
    if (nsrc == ndst) src_s = 18'(smp_q[oc_q]);
    else if (nsrc == CW'(1) && ndst == CW'(2)) src_s = 18'(smp_q[0]);
    else if (nsrc == CW'(2) && ndst == CW'(1))
      src_s = (18'(smp_q[0]) + 18'(smp_q[IW'(1)])) >>> 1;
    else src_s = 18'(smp_q[mod_q]);
  end

  // shaping filter, divide by 10 toward zero through the magnitude
  logic signed [22:0] shx;
  logic [21:0]        shm;
  logic [44:0]        shpp;
  logic signed [19:0] shp;
  always_comb begin
    shx  = 23'(eh_q[oc_q][0]) * 23'sd25 - 23'(eh_q[oc_q][1]) * 23'sd20
           + 23'(eh_q[oc_q][2]) * 23'sd5;
    shm  = shx[22] ? 22'(-shx) : 22'(shx);
    shpp = 45'(shm) * 45'(Recip10);
    shp  = shx[22] ? -20'(shpp[44:26]) : 20'(shpp[44:26]);
  end

  // quantize
  logic signed [17:0] dith;
  logic signed [19:0] fb, sum;
  logic signed [16:0] sc;
  logic signed [16:0] qs;
  logic signed [32:0] half, maxv, minv, qn;
  always_comb begin
    dith = (18'($signed({3'b0, r1_q})) - 18'($signed({3'b0, lcg_out[30:16]})))
           >>> bits;
    case (qm_q)
      ard_pkg::QM_EFB:   fb = 20'(eh_q[oc_q][0]);
      ard_pkg::QM_TPDF:  fb = 20'(eh_q[oc_q][0]) + 20'(dith);
      ard_pkg::QM_SHAPE: fb = shp_q;
      default:           fb = '0;
    endcase
    sum = 20'(src_s) + fb;
    sc  = (sum > 20'sd32767) ? 17'sd32767 : (sum < -20'sd32768) ? -17'sd32768 : 17'(sum);
    qs  = sc >>> sh;
    half = 33'sd1 <<< (bits - 6'd1);
    maxv = half - 33'sd1;
    minv = -half;
    if (narrow) qn = (33'(qs) > maxv) ? maxv : (33'(qs) < minv) ? minv : 33'(qs);
    else qn = 33'(src_s) <<< (bits - 6'd16);
  end

  // error update: shaping mode err*95/100 toward zero through the magnitude, else err*96 (err*85 at <= 6 bits) >>> 7
  logic signed [17:0] err;
  logic signed [25:0] leakp;
  logic [17:0]        em;
  logic [42:0]        e95p;
  logic signed [18:0] e95;
  logic signed [16:0] e_new;
  always_comb begin
    err   = 18'(s_q) - 18'(q_q <<< sh);
    leakp = 26'(err) * ((bits <= 6'd6) ? 26'sd85 : 26'sd96);
    em    = err[17] ? 18'(-err) : 18'(err);
    e95p  = 43'(em) * 43'(Recip95Pct);
    e95   = err[17] ? -19'(e95p[42:25]) : 19'(e95p[42:25]);
    if (qm_q == ard_pkg::QM_SHAPE)
      e_new = (e95 > 19'sd32767) ? 17'sd32767 : (e95 < -19'sd32768) ? -17'sd32768 : 17'(e95);
    else e_new = 17'(leakp >>> 7);
  end

  // packing
  logic [2:0]  nb;
  logic [5:0]  align;
  logic [31:0] u, wd;
  always_comb begin
    nb    = 3'((bits + 6'd7) >> 3);
    align = 6'({nb, 3'b0}) - bits;
    u     = 32'((sgn_q ? q_q : q_q + half) << align);
    wd    = '0;
    for (int b = 0; b < 4; b++) begin
      if (3'(b) < nb) begin
        if (le_q) wd[b*8 +: 8] = u[b*8 +: 8];
        else wd[b*8 +: 8] = u[(32'(nb) - 1 - b)*8 +: 8];
      end
    end
  end

  logic in_acc, out_acc, emit_go;
  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;
  assign emit_go = (state_q == ard_pkg::ST_EMIT) && (!out_v_q || out_acc);
  assign s_axis_tready = (state_q == ard_pkg::ST_IDLE);
  assign cfg_ready_o   = 1'b1;

  // next state
  always_comb begin
    state_d = state_q;
    oc_d    = oc_q;
    case (state_q)
      ard_pkg::ST_IDLE: if (in_acc) begin
        oc_d = '0;
        state_d = chan_st;
      end
      ard_pkg::ST_LCG1:  state_d = ard_pkg::ST_LCG2;
      ard_pkg::ST_LCG2:  state_d = ard_pkg::ST_QUANT;
      ard_pkg::ST_SHAPE: state_d = ard_pkg::ST_QUANT;
      ard_pkg::ST_QUANT: state_d = ard_pkg::ST_ERR;
      ard_pkg::ST_ERR:   state_d = ard_pkg::ST_EMIT;
      ard_pkg::ST_EMIT: if (!out_v_q || out_acc) begin
        if (32'(oc_q) + 1 == 32'(ndst)) begin
          oc_d = '0;
          state_d = fin_q ? ard_pkg::ST_CLEAR : ard_pkg::ST_IDLE;
        end else begin
          oc_d = oc_q + IW'(1);
          state_d = chan_st;
        end
      end
      ard_pkg::ST_CLEAR: if (32'(oc_q) + 1 == MAX_CHANNELS) begin
        oc_d = '0;
        state_d = ard_pkg::ST_IDLE;
      end else oc_d = oc_q + IW'(1);
      default: state_d = ard_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ard_pkg::ST_IDLE;
      oc_q    <= '0;
      mod_q   <= '0;
      out_v_q <= 1'b0;
      src_q <= 4'd2; dst_q <= 4'd2; bits_q <= 6'd16;
      sgn_q <= 1'b1; le_q <= 1'b1; qm_q <= 2'd0;
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        seed_q[i] <= '0;
        for (int j = 0; j < 3; j++) eh_q[i][j] <= '0;
      end
    end else begin
      state_q <= state_d;
      oc_q    <= oc_d;
      if (emit_go) out_v_q <= 1'b1;
      else if (out_acc) out_v_q <= 1'b0;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          ard_pkg::REG_SRC_CH: src_q  <= cfg_data_i[3:0];
          ard_pkg::REG_DST_CH: dst_q  <= cfg_data_i[3:0];
          ard_pkg::REG_BITS:   bits_q <= cfg_data_i[5:0];
          ard_pkg::REG_SIGNED: sgn_q  <= cfg_data_i[0];
          ard_pkg::REG_LITTLE: le_q   <= cfg_data_i[0];
          ard_pkg::REG_QMODE:  qm_q   <= cfg_data_i[1:0];
          default: ;
        endcase
      end
      case (state_q)
        ard_pkg::ST_IDLE: if (in_acc) mod_q <= '0;
        ard_pkg::ST_LCG2: seed_q[oc_q] <= lcg_out;
        ard_pkg::ST_QUANT: if (qm_q == ard_pkg::QM_TPDF && narrow)
          seed_q[oc_q] <= lcg_out;
        ard_pkg::ST_ERR: if (narrow && qm_q != ard_pkg::QM_TRUNC) begin
          eh_q[oc_q][0] <= e_new;
          if (qm_q == ard_pkg::QM_SHAPE) begin
            eh_q[oc_q][1] <= eh_q[oc_q][0];
            eh_q[oc_q][2] <= eh_q[oc_q][1];
          end
        end
        ard_pkg::ST_EMIT: if (!out_v_q || out_acc) begin
          mod_q <= (32'(mod_q) + 1 >= 32'(nsrc)) ? '0 : mod_q + IW'(1);
        end
        ard_pkg::ST_CLEAR: begin
          seed_q[oc_q] <= '0;
          for (int j = 0; j < 3; j++) eh_q[oc_q][j] <= '0;
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      for (int i = 0; i < MAX_CHANNELS; i++) smp_q[i] <= s_axis_tdata[i*16 +: 16];
      fin_q <= s_axis_tlast;
    end
    if (state_q == ard_pkg::ST_LCG2) r1_q <= lcg_out[30:16];
    if (state_q == ard_pkg::ST_SHAPE) shp_q <= shp;
    if (state_q == ard_pkg::ST_QUANT) begin
      s_q <= sc;
      q_q <= qn;
    end
    if (state_q == ard_pkg::ST_EMIT && (!out_v_q || out_acc)) begin
      word_q <= wd;
      nb_q   <= nb;
      last_q <= (32'(oc_q) + 1 == 32'(ndst));
    end
  end

  // output channel index follows the word
  logic [2:0] och_q;
  always_ff @(posedge clk_i) begin
    if (state_q == ard_pkg::ST_EMIT && (!out_v_q || out_acc)) och_q <= 3'(oc_q);
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = word_q;
  assign m_axis_tuser  = {2'b00, nb_q, och_q};
  assign m_axis_tlast  = last_q;

  // assertions
  a_no_in_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ard_pkg::ST_IDLE) |-> !s_axis_tready)
    else $error("input ready while busy");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("output word dropped under stall");
  a_clear_idle_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ard_pkg::ST_CLEAR) |-> !in_acc)
    else $error("input taken during clear sweep");

endmodule
